// ----- hdl/lslf_pkg.sv -----
// Shared types and fixed constants for the least-squares line fit block.
// No dependencies; used by lslf_fit and the top level.

package lslf_pkg;

    // Result field widths, fixed by the output format
    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 48;

    // Fit status codes
    typedef enum logic [1:0] {
        FS_OK   = 2'd0,
        FS_FEW  = 2'd1,
        FS_OVER = 2'd2,
        FS_SAT  = 2'd3
    } t_fit_status;

    // Status from the fit engine towards the top level
    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_fit_flags;

endpackage

// ----- hdl/lslf_alu.sv -----
// Shared adder/subtractor used by the fit sequencer for every arithmetic step.
// No dependencies.

module lslf_alu #(
    parameter int WIDTH = 59
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_res,
    output logic             o_carry
);

    logic [WIDTH:0] w_sum;

    // a + b, or a - b as a + ~b + 1; on subtract carry set means a >= b
    assign w_sum   = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)}
                   + {{WIDTH{1'b0}}, i_sub};
    assign o_res   = w_sum[WIDTH-1:0];
    assign o_carry = w_sum[WIDTH];

endmodule

// ----- hdl/lslf_accum.sv -----
// Point counter and running sums of x, y, x*x and x*y for one set of samples.
// No dependencies.

module lslf_accum #(
    parameter int MAX_POINTS = 32,
    parameter int X_BITS     = 10,
    parameter int Y_BITS     = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_take,
    input  logic [X_BITS-1:0]                      i_x,
    input  logic [Y_BITS-1:0]                      i_y,
    input  logic                                   i_clear,
    output logic [$clog2(MAX_POINTS+1)-1:0]        o_count,
    output logic [X_BITS+$clog2(MAX_POINTS)-1:0]   o_sum_x,
    output logic [Y_BITS+$clog2(MAX_POINTS)-1:0]   o_sum_y,
    output logic [2*X_BITS+$clog2(MAX_POINTS)-1:0] o_sum_xx,
    output logic [X_BITS+Y_BITS+$clog2(MAX_POINTS)-1:0] o_sum_xy,
    output logic                                   o_overflow
);

    localparam int L    = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SXW  = X_BITS + L;
    localparam int SYW  = Y_BITS + L;
    localparam int SXXW = 2 * X_BITS + L;
    localparam int SXYW = X_BITS + Y_BITS + L;
    localparam int XXW  = 2 * X_BITS;
    localparam int XYW  = X_BITS + Y_BITS;

    logic [CW-1:0]   r_count;
    logic [SXW-1:0]  r_sum_x;
    logic [SYW-1:0]  r_sum_y;
    logic [SXXW-1:0] r_sum_xx;
    logic [SXYW-1:0] r_sum_xy;
    logic            r_overflow;

    logic [XXW-1:0]  w_xx;
    logic [XYW-1:0]  w_xy;
    logic            w_full;

    // Per-point products
    assign w_xx   = XXW'(i_x) * XXW'(i_x);
    assign w_xy   = XYW'(i_x) * XYW'(i_y);
    assign w_full = (r_count >= CW'(MAX_POINTS));

    // Accumulate; a point beyond the limit is dropped and flagged
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count    <= '0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_sum_xx   <= '0;
            r_sum_xy   <= '0;
            r_overflow <= 1'b0;
        end else if (i_take) begin
            if (w_full) begin
                r_overflow <= 1'b1;
            end else begin
                r_count  <= r_count + CW'(1);
                r_sum_x  <= r_sum_x + SXW'(i_x);
                r_sum_y  <= r_sum_y + SYW'(i_y);
                r_sum_xx <= r_sum_xx + SXXW'(w_xx);
                r_sum_xy <= r_sum_xy + SXYW'(w_xy);
            end
        end
    end

    assign o_count    = r_count;
    assign o_sum_x    = r_sum_x;
    assign o_sum_y    = r_sum_y;
    assign o_sum_xx   = r_sum_xx;
    assign o_sum_xy   = r_sum_xy;
    assign o_overflow = r_overflow;

endmodule

// ----- hdl/lslf_fit.sv -----
// Fit sequencer: shift-add products, differences and restoring divisions, all
// through one shared lslf_alu. Depends on lslf_pkg and lslf_alu.

module lslf_fit #(
    parameter int MAX_POINTS = 32,
    parameter int X_BITS     = 10,
    parameter int Y_BITS     = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic                                   i_take,
    input  logic [$clog2(MAX_POINTS+1)-1:0]        i_count,
    input  logic [X_BITS+$clog2(MAX_POINTS)-1:0]   i_sum_x,
    input  logic [Y_BITS+$clog2(MAX_POINTS)-1:0]   i_sum_y,
    input  logic [2*X_BITS+$clog2(MAX_POINTS)-1:0] i_sum_xx,
    input  logic [X_BITS+Y_BITS+$clog2(MAX_POINTS)-1:0] i_sum_xy,
    input  logic                                   i_overflow,
    output lslf_pkg::t_fit_flags                   o_flags,
    output logic [lslf_pkg::SLOPE_W-1:0]           o_slope,
    output logic [lslf_pkg::ICPT_W-1:0]            o_icpt,
    output lslf_pkg::t_fit_status                  o_status
);

    localparam int L    = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SXW  = X_BITS + L;
    localparam int SYW  = Y_BITS + L;
    localparam int SXXW = 2 * X_BITS + L;
    localparam int SXYW = X_BITS + Y_BITS + L;
    // widest product and the widest quotient with one rounding bit
    localparam int PW   = SXXW + SYW;
    localparam int QW   = PW + FRAC_BITS + 1;
    localparam int AW   = (QW > lslf_pkg::ICPT_W + 1) ? QW : lslf_pkg::ICPT_W + 1;
    localparam int MW   = (SXW > SYW) ? SXW : SYW;
    localparam int MCW  = (SXXW > SXYW) ? SXXW : SXYW;
    localparam int CNTW = $clog2(AW);

    localparam logic [AW-1:0] SLOPE_HALF = AW'(1) << (lslf_pkg::SLOPE_W - 1);
    localparam logic [AW-1:0] ICPT_HALF  = AW'(1) << (lslf_pkg::ICPT_W - 1);
    localparam logic [AW-1:0] SLOPE_MAX  = SLOPE_HALF - AW'(1);
    localparam logic [AW-1:0] ICPT_MAX   = ICPT_HALF - AW'(1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_SETUP, ST_MUL, ST_SUB,
        ST_NEG, ST_DIV, ST_RND, ST_FIX, ST_DONE
    } t_state;

    // Which product is formed; pairs are (positive, negative) terms
    typedef enum logic [2:0] {
        SP_N_SXX, SP_SX_SX, SP_N_SXY, SP_SX_SY, SP_SXX_SY, SP_SX_SXY
    } t_step;

    t_state                        r_state, n_state;
    t_step                         r_step, n_step;
    logic [CNTW-1:0]               r_cnt, n_cnt;
    logic [AW-1:0]                 r_acc, n_acc;
    logic [AW-1:0]                 r_hold, n_hold;
    logic [MCW-1:0]                r_mcand, n_mcand;
    logic [MW-1:0]                 r_mplier, n_mplier;
    logic [PW-1:0]                 r_den, n_den;
    logic                          r_neg, n_neg;
    logic [lslf_pkg::SLOPE_W-1:0]  r_slope, n_slope;
    logic [lslf_pkg::ICPT_W-1:0]   r_icpt, n_icpt;
    lslf_pkg::t_fit_status         r_status, n_status;

    logic [AW-1:0] w_alu_a, w_alu_b, w_alu_res;
    logic          w_alu_sub, w_alu_carry;
    logic [AW-1:0] w_rem_shift;
    logic [AW-1:0] w_q;
    logic [AW-1:0] w_half, w_max, w_fix_val;
    logic          w_over;
    logic [MCW-1:0] w_mcand;
    logic [MW-1:0]  w_mplier;

    lslf_alu #(.WIDTH(AW)) u_alu (
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .i_sub   (w_alu_sub),
        .o_res   (w_alu_res),
        .o_carry (w_alu_carry)
    );

    // Division and rounding views of the working registers
    assign w_rem_shift = {r_hold[AW-2:0], r_acc[AW-1]};
    assign w_q         = {1'b0, r_acc[AW-1:1]};

    // Saturation limits for the field being finished
    always_comb begin
        if (r_step == SP_SX_SY) begin
            w_half = SLOPE_HALF;
            w_max  = SLOPE_MAX;
        end else begin
            w_half = ICPT_HALF;
            w_max  = ICPT_MAX;
        end
        w_over = r_neg ? (w_q > w_half) : (w_q >= w_half);
        if (w_over) begin
            w_fix_val = r_neg ? w_half : w_max;
        end else begin
            w_fix_val = r_neg ? w_alu_res : w_q;
        end
    end

    // Shared unit operand selection
    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        case (r_state)
            ST_MUL: begin
                w_alu_a = {r_acc[AW-2:0], 1'b0};
                w_alu_b = r_mplier[MW-1] ? AW'(r_mcand) : '0;
            end
            ST_SUB: begin
                w_alu_a   = r_hold;
                w_alu_b   = r_acc;
                w_alu_sub = 1'b1;
            end
            ST_NEG: begin
                w_alu_a   = r_acc;
                w_alu_b   = r_hold;
                w_alu_sub = 1'b1;
            end
            ST_DIV: begin
                w_alu_a   = w_rem_shift;
                w_alu_b   = AW'(r_den);
                w_alu_sub = 1'b1;
            end
            ST_RND: begin
                w_alu_a = r_acc;
                w_alu_b = AW'(1);
            end
            ST_FIX: begin
                w_alu_b   = w_q;
                w_alu_sub = 1'b1;
            end
            default: begin
                w_alu_a = '0;
            end
        endcase
    end

    // Product operands for each step
    always_comb begin
        unique case (r_step)
            SP_N_SXX: begin
                w_mcand  = MCW'(i_sum_xx);
                w_mplier = MW'(i_count);
            end
            SP_SX_SX: begin
                w_mcand  = MCW'(i_sum_x);
                w_mplier = MW'(i_sum_x);
            end
            SP_N_SXY: begin
                w_mcand  = MCW'(i_sum_xy);
                w_mplier = MW'(i_count);
            end
            SP_SX_SY: begin
                w_mcand  = MCW'(i_sum_y);
                w_mplier = MW'(i_sum_x);
            end
            SP_SXX_SY: begin
                w_mcand  = MCW'(i_sum_xx);
                w_mplier = MW'(i_sum_y);
            end
            SP_SX_SXY: begin
                w_mcand  = MCW'(i_sum_xy);
                w_mplier = MW'(i_sum_x);
            end
            default: begin
                w_mcand  = '0;
                w_mplier = '0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_hold   = r_hold;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_den    = r_den;
        n_neg    = r_neg;
        n_slope  = r_slope;
        n_icpt   = r_icpt;
        n_status = r_status;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state  = ST_CHECK;
                    n_slope  = '0;
                    n_icpt   = '0;
                    n_status = lslf_pkg::FS_OK;
                end
            end
            ST_CHECK: begin
                if (i_overflow) begin
                    n_status = lslf_pkg::FS_OVER;
                    n_state  = ST_DONE;
                end else if (i_count < CW'(2)) begin
                    n_status = lslf_pkg::FS_FEW;
                    n_state  = ST_DONE;
                end else begin
                    n_step  = SP_N_SXX;
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_mcand  = w_mcand;
                n_mplier = w_mplier;
                n_acc    = '0;
                n_cnt    = '0;
                n_state  = ST_MUL;
            end
            // MSB-first shift-add, one multiplier bit a cycle
            ST_MUL: begin
                n_acc    = w_alu_res;
                n_mplier = {r_mplier[MW-2:0], 1'b0};
                n_cnt    = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(MW - 1)) begin
                    case (r_step) inside
                        SP_N_SXX: begin
                            n_hold  = w_alu_res;
                            n_step  = SP_SX_SX;
                            n_state = ST_SETUP;
                        end
                        SP_N_SXY: begin
                            n_hold  = w_alu_res;
                            n_step  = SP_SX_SY;
                            n_state = ST_SETUP;
                        end
                        SP_SXX_SY: begin
                            n_hold  = w_alu_res;
                            n_step  = SP_SX_SXY;
                            n_state = ST_SETUP;
                        end
                        SP_SX_SX, SP_SX_SY, SP_SX_SXY: begin
                            n_state = ST_SUB;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            // positive term minus negative term
            ST_SUB: begin
                if (r_step == SP_SX_SX) begin
                    if (!w_alu_carry || (w_alu_res == '0)) begin
                        n_status = lslf_pkg::FS_FEW;
                        n_state  = ST_DONE;
                    end else begin
                        n_den   = w_alu_res[PW-1:0];
                        n_step  = SP_N_SXY;
                        n_state = ST_SETUP;
                    end
                end else begin
                    n_neg = !w_alu_carry;
                    if (!w_alu_carry) begin
                        n_state = ST_NEG;
                    end else begin
                        n_acc   = w_alu_res << (FRAC_BITS + 1);
                        n_hold  = '0;
                        n_cnt   = '0;
                        n_state = ST_DIV;
                    end
                end
            end
            // magnitude of a negative difference
            ST_NEG: begin
                n_acc   = w_alu_res << (FRAC_BITS + 1);
                n_hold  = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            // restoring division, one quotient bit a cycle
            ST_DIV: begin
                n_hold = w_alu_carry ? w_alu_res : w_rem_shift;
                n_acc  = {r_acc[AW-2:0], w_alu_carry};
                n_cnt  = r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(AW - 1)) begin
                    n_state = ST_RND;
                end
            end
            // round half away from zero on the magnitude
            ST_RND: begin
                n_acc   = w_alu_res;
                n_state = ST_FIX;
            end
            // sign, saturate and store
            ST_FIX: begin
                if (w_over) begin
                    n_status = lslf_pkg::FS_SAT;
                end
                if (r_step == SP_SX_SY) begin
                    n_slope = w_fix_val[lslf_pkg::SLOPE_W-1:0];
                    n_step  = SP_SXX_SY;
                    n_state = ST_SETUP;
                end else begin
                    n_icpt  = w_fix_val[lslf_pkg::ICPT_W-1:0];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= SP_N_SXX;
            r_cnt    <= '0;
            r_status <= lslf_pkg::FS_OK;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_cnt    <= n_cnt;
            r_status <= n_status;
        end
        r_acc    <= n_acc;
        r_hold   <= n_hold;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_den    <= n_den;
        r_neg    <= n_neg;
        r_slope  <= n_slope;
        r_icpt   <= n_icpt;
    end

    assign o_flags.busy      = (r_state != ST_IDLE);
    assign o_flags.res_valid = (r_state == ST_DONE);
    assign o_slope           = r_slope;
    assign o_icpt            = r_icpt;
    assign o_status          = r_status;

    // A fit starts only from idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("fit started while busy");

    // Division never runs on a zero denominator
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_den != '0))
        else $error("division by zero denominator");

    // A finished result holds until handed over
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_take) |=>
        (r_state == ST_DONE && $stable(r_slope) && $stable(r_icpt)))
        else $error("fit result changed before hand-over");

    // Degenerate and overflowed sets report zero slope and intercept
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (r_status == lslf_pkg::FS_FEW ||
         r_status == lslf_pkg::FS_OVER)) |-> (r_slope == '0 && r_icpt == '0))
        else $error("non-zero result with failure status");

endmodule

// ----- hdl/least_squares_line_fit.sv -----
// Top level of the least-squares line fit: accumulator, fit sequencer and
// output register. Depends on lslf_pkg, lslf_accum, lslf_fit (and lslf_alu).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one (x, y) sample per item
//   with i_last_point marking the final sample of a set. Output channel
//   (o_out_valid / i_out_ready) carries one result item per set: slope and
//   intercept in two's complement with FRAC_BITS fraction bits, the number of
//   points used and a status (ok, too few points or zero spread in x, too
//   many points, saturated).
//   Samples that are not last are taken one per cycle while no fit is running.
//   A last sample starts the fit, which runs six shift-add products (one
//   multiplier bit a cycle) and two restoring divisions (one quotient bit a
//   cycle) in one shared adder/subtractor. o_in_ready is low from the last
//   sample until the result moves into the output register.
//   The output register holds one result; while the receiver stalls, the
//   next set is accumulated, and its fit result waits inside the sequencer.
//   Reset (synchronous, active low) clears the sums, the count, the sequencer
//   and the output valid.

module least_squares_line_fit #(
    parameter int MAX_POINTS = 32,
    parameter int X_BITS     = 10,
    parameter int Y_BITS     = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [X_BITS-1:0]                  i_x_value,
    input  logic [Y_BITS-1:0]                  i_y_value,
    input  logic                               i_last_point,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [lslf_pkg::SLOPE_W-1:0]       o_slope_q16,
    output logic [lslf_pkg::ICPT_W-1:0]        o_intercept_q16,
    output logic [$clog2(MAX_POINTS+1)-1:0]    o_points_used,
    output logic [1:0]                         o_fit_status
);

    localparam int L    = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SXW  = X_BITS + L;
    localparam int SYW  = Y_BITS + L;
    localparam int SXXW = 2 * X_BITS + L;
    localparam int SXYW = X_BITS + Y_BITS + L;

    logic                         w_in_take, w_start, w_res_take;
    lslf_pkg::t_fit_flags         w_flags;
    logic [CW-1:0]                w_count;
    logic [SXW-1:0]               w_sum_x;
    logic [SYW-1:0]               w_sum_y;
    logic [SXXW-1:0]              w_sum_xx;
    logic [SXYW-1:0]              w_sum_xy;
    logic                         w_overflow;
    logic [lslf_pkg::SLOPE_W-1:0] w_slope;
    logic [lslf_pkg::ICPT_W-1:0]  w_icpt;
    lslf_pkg::t_fit_status        w_status;

    logic                         r_out_valid;
    logic [lslf_pkg::SLOPE_W-1:0] r_slope;
    logic [lslf_pkg::ICPT_W-1:0]  r_icpt;
    logic [CW-1:0]                r_points;
    lslf_pkg::t_fit_status        r_status;

    // Handshake
    assign o_in_ready = !w_flags.busy;
    assign w_in_take  = i_in_valid && o_in_ready;
    assign w_start    = w_in_take && i_last_point;
    assign w_res_take = w_flags.res_valid && (!r_out_valid || i_out_ready);

    lslf_accum #(
        .MAX_POINTS (MAX_POINTS),
        .X_BITS     (X_BITS),
        .Y_BITS     (Y_BITS)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_in_take),
        .i_x        (i_x_value),
        .i_y        (i_y_value),
        .i_clear    (w_res_take),
        .o_count    (w_count),
        .o_sum_x    (w_sum_x),
        .o_sum_y    (w_sum_y),
        .o_sum_xx   (w_sum_xx),
        .o_sum_xy   (w_sum_xy),
        .o_overflow (w_overflow)
    );

    lslf_fit #(
        .MAX_POINTS (MAX_POINTS),
        .X_BITS     (X_BITS),
        .Y_BITS     (Y_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_fit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_take     (w_res_take),
        .i_count    (w_count),
        .i_sum_x    (w_sum_x),
        .i_sum_y    (w_sum_y),
        .i_sum_xx   (w_sum_xx),
        .i_sum_xy   (w_sum_xy),
        .i_overflow (w_overflow),
        .o_flags    (w_flags),
        .o_slope    (w_slope),
        .o_icpt     (w_icpt),
        .o_status   (w_status)
    );

    // Output register; the sums are cleared as the result moves in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_take) begin
            r_slope  <= w_slope;
            r_icpt   <= w_icpt;
            r_points <= w_count;
            r_status <= w_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_slope_q16     = r_slope;
    assign o_intercept_q16 = r_icpt;
    assign o_points_used   = r_points;
    assign o_fit_status    = r_status;

endmodule
